// ----- hw/rtl/lec_pkg.sv -----
// shared types and constants for the line edit character queue
// no dependencies; used by lec_cell and line_edit_char_queue
`default_nettype none

package lec_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    localparam logic [7:0]  BYTE_BACKSPACE = 8'h08;
    localparam logic [7:0]  BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0]  BYTE_NUL       = 8'h00;
    localparam logic [15:0] LINE_MAX       = 16'hFFFF;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic       shift;
        logic [7:0] wdata;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/line_edit_char_queue.sv -----
// line edit character queue: a chain of byte cells with the head at cell 0
// depends on lec_pkg and lec_cell
//
// usage:
//   input channel i_in_valid / o_in_stall carries one request (i_command,
//   i_data_byte). write appends a byte or erases the last one on backspace,
//   read drops NUL bytes at the head then takes one byte, flush empties it.
//   output channel o_out_valid / i_out_stall returns one result per request.
//   config channel i_cfg_valid / o_cfg_ready sets backspace_literal; write it
//   only while no request is in flight.
// sequence:
//   a request is taken in idle and finished in the exec state, and no new
//   request is taken until then; a read first discards each NUL byte at the
//   head, one per shift of the cell chain, which moves by exactly one position.
//   results land in an output register when the exec state finishes.
// stall:
//   while the output register is still held by i_out_stall, both the NUL skip
//   and the finishing step wait and o_in_stall stays high. reset clears fill
//   level, line count, config and the output valid flag; cells are not cleared.
`default_nettype none

module line_edit_char_queue #(
    parameter int CAPACITY = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [7:0]                    i_data_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_read_byte,
    output logic                               o_read_valid,
    output logic                               o_write_accepted,
    output logic [$clog2(CAPACITY + 1)-1:0]    o_fill_level,
    output logic [15:0]                        o_line_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_data
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);

    lec_pkg::t_state    r_state, n_state;
    lec_pkg::t_cmd      r_cmd;
    logic [7:0]         r_data;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [15:0]        r_lines, n_lines;
    logic               r_bs_literal;

    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_read_byte, n_read_byte;
    logic               r_read_valid, n_read_valid;
    logic               r_write_accepted, n_write_accepted;

    logic               in_accept;
    logic               out_free;
    logic               nul_head;
    logic               skip;
    logic               finish;
    logic               wr_en;
    lec_pkg::t_cell_ctl cell_ctl;
    logic [7:0]         cell_data [CAPACITY];
    logic [7:0]         head;
    logic               not_empty;
    logic               not_full;
    logic               erase;

    assign head      = cell_data[0];
    assign not_empty = (r_fill != '0);
    assign not_full  = (r_fill < FILL_W'(CAPACITY));
    assign erase     = (r_data == lec_pkg::BYTE_BACKSPACE) && !r_bs_literal;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign nul_head  = (r_cmd == lec_pkg::CMD_READ) && not_empty &&
                       (head == lec_pkg::BYTE_NUL);

    // the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [7:0] next_data;
            if (gi == CAPACITY - 1) begin : g_last
                assign next_data = lec_pkg::BYTE_NUL;
            end else begin : g_mid
                assign next_data = cell_data[gi+1];
            end
            lec_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_we        (wr_en && (r_fill[IDX_W-1:0] == IDX_W'(gi))),
                .i_next_data (next_data),
                .o_data      (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state          = r_state;
        n_fill           = r_fill;
        n_lines          = r_lines;
        n_out_valid      = r_out_valid && i_out_stall;
        n_read_byte      = r_read_byte;
        n_read_valid     = r_read_valid;
        n_write_accepted = r_write_accepted;
        skip             = 1'b0;
        finish           = 1'b0;
        wr_en            = 1'b0;
        cell_ctl.shift   = 1'b0;
        cell_ctl.wdata   = r_data;

        unique case (r_state)
            lec_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = lec_pkg::S_EXEC;
                end
            end
            lec_pkg::S_EXEC: begin
                // read discards one NUL at the head per cycle while the output register is free;
                // the held result keeps its fill level and line count until it is taken
                skip   = nul_head && out_free;
                finish = !nul_head && out_free;
                if (skip) begin
                    cell_ctl.shift = 1'b1;
                    n_fill         = r_fill - FILL_W'(1);
                    if (r_lines != '0) begin
                        n_lines = r_lines - 16'd1;
                    end
                end else if (finish) begin
                    n_state          = lec_pkg::S_IDLE;
                    n_out_valid      = 1'b1;
                    n_read_byte      = lec_pkg::BYTE_NUL;
                    n_read_valid     = 1'b0;
                    n_write_accepted = 1'b0;
                    unique case (r_cmd)
                        lec_pkg::CMD_WRITE: begin
                            if (not_full) begin
                                if (erase) begin
                                    if (not_empty) begin
                                        n_fill           = r_fill - FILL_W'(1);
                                        n_write_accepted = 1'b1;
                                    end
                                end else begin
                                    wr_en            = 1'b1;
                                    n_fill           = r_fill + FILL_W'(1);
                                    n_write_accepted = 1'b1;
                                    if ((r_data == lec_pkg::BYTE_NEWLINE ||
                                         r_data == lec_pkg::BYTE_NUL) &&
                                        r_lines != lec_pkg::LINE_MAX) begin
                                        n_lines = r_lines + 16'd1;
                                    end
                                end
                            end
                        end
                        lec_pkg::CMD_READ: begin
                            if (not_empty) begin
                                cell_ctl.shift = 1'b1;
                                n_fill         = r_fill - FILL_W'(1);
                                n_read_byte    = head;
                                n_read_valid   = 1'b1;
                                if (head == lec_pkg::BYTE_NEWLINE && r_lines != '0) begin
                                    n_lines = r_lines - 16'd1;
                                end
                            end
                        end
                        lec_pkg::CMD_FLUSH: begin
                            n_fill  = '0;
                            n_lines = '0;
                        end
                        default: begin
                            // unused command code: report state only
                        end
                    endcase
                end
            end
            default: begin
                n_state = lec_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lec_pkg::S_IDLE;
            r_fill       <= '0;
            r_lines      <= '0;
            r_bs_literal <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_lines     <= n_lines;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bs_literal <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= lec_pkg::t_cmd'(i_command);
            r_data <= i_data_byte;
        end
        r_read_byte      <= n_read_byte;
        r_read_valid     <= n_read_valid;
        r_write_accepted <= n_write_accepted;
    end

    assign o_in_stall       = (r_state != lec_pkg::S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_read_byte      = r_read_byte;
    assign o_read_valid     = r_read_valid;
    assign o_write_accepted = r_write_accepted;
    assign o_fill_level     = r_fill;
    assign o_line_count     = r_lines;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("fill level above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == lec_pkg::S_EXEC))
        else $error("accepted request did not start");

    a_skip_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lec_pkg::S_EXEC && skip) |=>
            (r_fill == $past(r_fill) - FILL_W'(1)) && !o_out_valid)
        else $error("NUL skip did not pop exactly one byte");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_cmd == lec_pkg::CMD_FLUSH) |=>
            (r_fill == '0) && (r_lines == '0) && o_out_valid)
        else $error("flush left bytes or lines behind");

endmodule

`default_nettype wire

// ----- hw/rtl/lec_cell.sv -----
// one byte cell of the queue chain; shifts toward the head or loads a byte
// depends on lec_pkg
`default_nettype none

module lec_cell (
    input  wire logic               i_clk,
    input  wire lec_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_we,
    input  wire logic [7:0]         i_next_data,
    output logic [7:0]              o_data
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        priority if (i_ctl.shift) begin
            n_data = i_next_data;
        end else if (i_we) begin
            n_data = i_ctl.wdata;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ----- dv/line_edit_char_queue_test.sv -----
// self-checking bench for line_edit_char_queue: directed and random requests
// checked against an inline model; depends on lec_pkg and the queue rtl
`timescale 1ns / 100ps

module line_edit_char_queue_test;

    localparam int         DEPTH     = 256;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data;
    } t_request;

    typedef struct packed {
        logic [7:0]  rbyte;
        logic        rvalid;
        logic        accepted;
        logic [8:0]  fill;
        logic [15:0] lines;
    } t_status;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_command   = lec_pkg::CMD_WRITE;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_write_accepted;
    logic [8:0]  o_fill_level;
    logic [15:0] o_line_count;
    logic        o_cfg_ready;

    line_edit_char_queue #(.CAPACITY(DEPTH)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_byte      (o_read_byte),
        .o_read_valid     (o_read_valid),
        .o_write_accepted (o_write_accepted),
        .o_fill_level     (o_fill_level),
        .o_line_count     (o_line_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // model of the queue
    logic [7:0] ring_bytes [DEPTH];
    int         ring_head  = 0;
    int         ring_fill  = 0;
    int         term_count = 0;
    bit         bs_literal = 1'b0;

    t_request keystroke_q[$];
    t_status  predicted_q[$];
    int       queued_total   = 0;
    int       accepted_total = 0;
    int       real_items     = 0;
    int       mismatches     = 0;

    bit       in_taken   = 1'b0;
    bit       out_taken  = 1'b0;
    int       in_gap     = 0;
    int       out_hold   = 0;
    int       in_streak  = 0;
    int       out_streak = 0;
    bit       in_calm    = 1'b0;
    bit       out_calm   = 1'b0;

    function automatic t_status apply_request(t_request r);
        t_status    s;
        logic [7:0] b;
        s = '0;
        if (r.command == lec_pkg::CMD_WRITE) begin
            if (ring_fill < DEPTH) begin
                if (r.data == lec_pkg::BYTE_BACKSPACE && !bs_literal) begin
                    if (ring_fill > 0) begin
                        ring_fill--;
                        s.accepted = 1'b1;
                    end
                end else begin
                    ring_bytes[(ring_head + ring_fill) % DEPTH] = r.data;
                    ring_fill++;
                    s.accepted = 1'b1;
                    if ((r.data == lec_pkg::BYTE_NEWLINE || r.data == lec_pkg::BYTE_NUL) &&
                        term_count < lec_pkg::LINE_MAX)
                        term_count++;
                end
            end
        end else if (r.command == lec_pkg::CMD_READ) begin
            // NUL bytes at the head are dropped and each one retires a line
            while (ring_fill > 0 && ring_bytes[ring_head] == lec_pkg::BYTE_NUL) begin
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill--;
                if (term_count > 0) term_count--;
            end
            if (ring_fill > 0) begin
                b = ring_bytes[ring_head];
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill--;
                s.rbyte  = b;
                s.rvalid = 1'b1;
                if (b == lec_pkg::BYTE_NEWLINE && term_count > 0) term_count--;
            end
        end else if (r.command == lec_pkg::CMD_FLUSH) begin
            ring_fill  = 0;
            term_count = 0;
        end
        s.fill  = 9'(ring_fill);
        s.lines = 16'(term_count);
        return s;
    endfunction

    // stretches of calm or of random waits, each kind chosen at random
    function automatic int next_wait(inout int streak, inout bit calm);
        if (streak == 0) begin
            streak = $urandom_range(8, 60);
            calm   = ($urandom_range(0, 2) == 0);
        end
        streak--;
        if (calm) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_request r;
        if (i_in_valid && !in_taken) begin
            // stalled request stays put
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap     <= in_gap - 1;
        end else if (keystroke_q.size() != 0) begin
            r = keystroke_q.pop_front();
            i_command   <= r.command;
            i_data_byte <= r.data;
            i_in_valid  <= 1'b1;
            in_gap      <= next_wait(in_streak, in_calm);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result stall, counted down only while a result is offered
    always @(negedge i_clk) begin
        int n;
        n = out_taken ? next_wait(out_streak, out_calm) : out_hold;
        i_out_stall <= (n > 0);
        out_hold    <= (n > 0 && o_out_valid === 1'b1) ? n - 1 : n;
    end

    // monitor: predicts on each accepted request, checks each accepted result
    always @(posedge i_clk) begin
        t_request r;
        t_status  want;
        bit       req_fire, res_fire;
        req_fire = i_rst_n && i_in_valid && o_in_stall === 1'b0;
        res_fire = i_rst_n && o_out_valid === 1'b1 && !i_out_stall;
        in_taken  <= req_fire;
        out_taken <= res_fire;
        if (req_fire) begin
            r.command = i_command;
            r.data    = i_data_byte;
            predicted_q.push_back(apply_request(r));
            accepted_total++;
        end
        if (res_fire) begin
            if (predicted_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with no request pending, %s %0h",
                         $time, "expected none, actual fill", o_fill_level);
            end else begin
                want = predicted_q.pop_front();
                check_field("read_byte", want.rbyte, o_read_byte);
                check_field("read_valid", want.rvalid, o_read_valid);
                check_field("write_accepted", want.accepted, o_write_accepted);
                check_field("fill_level", want.fill, o_fill_level);
                check_field("line_count", want.lines, o_line_count);
            end
        end
    end

    task automatic put(logic [1:0] cmd, logic [7:0] b);
        t_request r;
        r.command = cmd;
        r.data    = b;
        keystroke_q.push_back(r);
        queued_total++;
        if (cmd != CMD_SPARE) real_items++;
    endtask

    task automatic drain();
        while (queued_total != accepted_total || predicted_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_backspace_literal(bit v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        bs_literal = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(int target);
        int         stop, len, pick;
        logic [7:0] b;
        logic [1:0] c;
        stop = real_items + target;
        while (real_items < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // a typed line, now and then corrected
                len = $urandom_range(0, 16);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       b = lec_pkg::BYTE_BACKSPACE;
                        1:       b = 8'($urandom_range(0, 255));
                        default: b = 8'($urandom_range(8'h20, 8'h7E));
                    endcase
                    put(lec_pkg::CMD_WRITE, b);
                end
                put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NEWLINE);
            end else if (pick < 80) begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++)
                    put(lec_pkg::CMD_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NUL);
                put(lec_pkg::CMD_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 98) begin
                c = 2'($urandom_range(0, 3));
                put(c, 8'($urandom_range(0, 255)));
            end else begin
                put(lec_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // fill to the brim, push on the full queue, then read it all back
    task automatic fill_to_capacity();
        logic [7:0] b;
        put(lec_pkg::CMD_FLUSH, 8'h00);
        for (int k = 0; k < DEPTH; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == lec_pkg::BYTE_BACKSPACE && !bs_literal) b = lec_pkg::BYTE_NEWLINE;
            put(lec_pkg::CMD_WRITE, b);
        end
        put(lec_pkg::CMD_WRITE, 8'hFF);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NUL);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NEWLINE);
        put(lec_pkg::CMD_READ, 8'h00);
        put(lec_pkg::CMD_WRITE, 8'h5A);
        for (int k = 0; k < DEPTH + 2; k++)
            put(lec_pkg::CMD_READ, 8'($urandom_range(0, 255)));
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_backspace_literal(1'b0);
        put(lec_pkg::CMD_WRITE, 8'hFF);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NUL);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NEWLINE);
        put(lec_pkg::CMD_WRITE, 8'h41);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        put(lec_pkg::CMD_READ, 8'hFF);
        put(lec_pkg::CMD_READ, 8'h00);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        put(lec_pkg::CMD_READ, 8'h55);
        put(CMD_SPARE, 8'h5A);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NUL);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NUL);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_NEWLINE);
        put(lec_pkg::CMD_READ, 8'hAA);
        put(lec_pkg::CMD_WRITE, 8'h7F);
        put(lec_pkg::CMD_FLUSH, 8'hAA);
        put(lec_pkg::CMD_READ, 8'h00);
        put(lec_pkg::CMD_WRITE, 8'h80);
        drain();

        set_backspace_literal(1'b1);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        put(lec_pkg::CMD_WRITE, 8'h01);
        put(lec_pkg::CMD_WRITE, lec_pkg::BYTE_BACKSPACE);
        for (int k = 0; k < 4; k++) put(lec_pkg::CMD_READ, 8'h00);
        random_traffic(210);
        drain();

        set_backspace_literal(1'b0);
        random_traffic(210);
        fill_to_capacity();
        drain();

        set_backspace_literal(1'b1);
        fill_to_capacity();
        random_traffic(210);
        drain();

        set_backspace_literal(1'b0);
        random_traffic(210);
        drain();

        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("line_edit_char_queue regression: pass");
        else
            $display("line_edit_char_queue regression: fail");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("line_edit_char_queue regression: fail");
        $finish;
    end

endmodule
